// ----- rtl/core/fts_pkg.sv -----
`timescale 1ns / 1ps
package fts_pkg;

    localparam int DEF_TASK_SLOTS = 16;
    localparam int TPU_W          = 10;
    localparam int UNITS_W        = 16;
    localparam int TICKS_W        = 32;
    localparam logic [TPU_W-1:0] TPU_RESET = 10'd100;

    typedef enum logic [1:0] {
        OP_CREATE    = 2'd0,
        OP_SLEEP     = 2'd1,
        OP_TERMINATE = 2'd2,
        OP_TICK      = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_SLOT = 2'd1,
        ST_IMAGE   = 2'd2,
        ST_NO_RUN  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        SLOT_FREE     = 2'd0,
        SLOT_READY    = 2'd1,
        SLOT_SLEEPING = 2'd2,
        SLOT_DONE     = 2'd3
    } slot_state_t;

    // Countdown unit: request and result between sequencer and decrementer.
    typedef struct packed {
        logic [TICKS_W-1:0] value;
    } cnt_req_t;

    typedef struct packed {
        logic               expire;
        logic [TICKS_W-1:0] value;
    } cnt_rsp_t;

endpackage

// ----- rtl/core/fts_count_unit.sv -----
`timescale 1ns / 1ps
// Shared countdown ALU: one compare and decrement per use.
module fts_count_unit
    import fts_pkg::*;
(
    input  cnt_req_t req,
    output cnt_rsp_t rsp
);

    always_comb
    begin
        rsp.expire = (req.value <= TICKS_W'(1));
        rsp.value  = rsp.expire ? '0 : req.value - TICKS_W'(1);
    end

endmodule

// ----- rtl/core/fts_seq.sv -----
`timescale 1ns / 1ps
// Scheduler sequencer: slot scan, queue updates, sleep list walk.
module fts_seq
    import fts_pkg::*;
#(
    parameter int TASK_SLOTS = DEF_TASK_SLOTS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [1:0]         op_in,
    input  logic [UNITS_W-1:0] units_in,
    input  logic               image_in,
    input  logic [TPU_W-1:0]   tpu,
    output logic               busy,
    output logic               done,
    output logic [1:0]         status,
    output logic [3:0]         new_id,
    output logic               run_valid,
    output logic [3:0]         run_id,
    output logic [4:0]         woken
);

    localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int CW = $clog2(TASK_SLOTS + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_MUL, S_TICK, S_TICKWR, S_DONE
    } state_t;

    state_t state_reg;
    slot_state_t slot_reg [TASK_SLOTS];
    logic [SW-1:0] rq_reg [TASK_SLOTS];
    logic [SW-1:0] so_reg [TASK_SLOTS];
    logic [TICKS_W-1:0] rem_reg [TASK_SLOTS];
    logic [SW-1:0] head_reg;
    logic [CW-1:0] rcnt_reg, scnt_reg, idx_reg, kept_reg;
    logic [UNITS_W-1:0] units_reg;
    logic image_reg;
    logic [SW-1:0] slot_sel_reg;
    logic [TICKS_W-1:0] rem_rd_reg;
    logic [4:0] woken_reg;
    logic [1:0] status_reg;
    logic [3:0] new_id_reg;

    cnt_req_t creq;
    cnt_rsp_t crsp;
    logic [CW:0]   tail_sum;
    logic [SW-1:0] tail_idx;
    logic [SW-1:0] head_inc;
    logic [SW-1:0] cur_slot;

    assign creq.value = rem_rd_reg;
    fts_count_unit u_cnt (.req(creq), .rsp(crsp));

    // circular queue indexes wrap at TASK_SLOTS
    assign tail_sum = (CW+1)'(head_reg) + (CW+1)'(rcnt_reg);
    assign tail_idx = (tail_sum >= (CW+1)'(TASK_SLOTS)) ?
                      SW'(tail_sum - (CW+1)'(TASK_SLOTS)) : SW'(tail_sum);
    assign head_inc = (head_reg == SW'(TASK_SLOTS - 1)) ? '0 : head_reg + 1'b1;
    assign cur_slot = so_reg[idx_reg[SW-1:0]];

    assign busy      = (state_reg != S_IDLE);
    assign done      = (state_reg == S_DONE);
    assign status    = status_reg;
    assign new_id    = new_id_reg;
    assign run_valid = (rcnt_reg != '0);
    assign run_id    = (rcnt_reg != '0) ? 4'(rq_reg[head_reg]) : 4'd0;
    assign woken     = woken_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            rcnt_reg  <= '0;
            scnt_reg  <= '0;
            for (int i = 0; i < TASK_SLOTS; i++)
                slot_reg[i] <= SLOT_FREE;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        units_reg  <= units_in;
                        image_reg  <= image_in;
                        idx_reg    <= '0;
                        kept_reg   <= '0;
                        woken_reg  <= '0;
                        status_reg <= ST_OK;
                        new_id_reg <= '0;
                        case (op_t'(op_in))
                            OP_CREATE: state_reg <= S_SCAN;
                            OP_TICK:   state_reg <= S_TICK;
                            default:
                            begin
                                if (rcnt_reg == '0)
                                begin
                                    status_reg <= ST_NO_RUN;
                                    state_reg  <= S_DONE;
                                end
                                else
                                begin
                                    slot_sel_reg <= rq_reg[head_reg];
                                    head_reg <= head_inc;
                                    rcnt_reg <= rcnt_reg - 1'b1;
                                    if (op_t'(op_in) == OP_TERMINATE)
                                    begin
                                        slot_reg[rq_reg[head_reg]] <= SLOT_DONE;
                                        state_reg <= S_DONE;
                                    end
                                    else
                                        state_reg <= S_MUL;
                                end
                            end
                        endcase
                    end
                end
                // one slot per cycle, lowest free first
                S_SCAN:
                begin
                    if (idx_reg == CW'(TASK_SLOTS))
                    begin
                        status_reg <= ST_NO_SLOT;
                        state_reg  <= S_DONE;
                    end
                    else if (slot_reg[idx_reg[SW-1:0]] == SLOT_FREE)
                    begin
                        if (!image_reg)
                            status_reg <= ST_IMAGE;
                        else
                        begin
                            slot_reg[idx_reg[SW-1:0]] <= SLOT_READY;
                            rq_reg[tail_idx] <= idx_reg[SW-1:0];
                            rcnt_reg   <= rcnt_reg + 1'b1;
                            new_id_reg <= 4'(idx_reg);
                        end
                        state_reg <= S_DONE;
                    end
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                // countdown load, sleeper appended to list tail
                S_MUL:
                begin
                    if (scnt_reg < CW'(TASK_SLOTS))
                    begin
                        slot_reg[slot_sel_reg] <= SLOT_SLEEPING;
                        rem_reg[slot_sel_reg]  <= TICKS_W'(units_reg) * TICKS_W'(tpu);
                        so_reg[scnt_reg[SW-1:0]] <= slot_sel_reg;
                        scnt_reg <= scnt_reg + 1'b1;
                    end
                    state_reg <= S_DONE;
                end
                // fetch next sleeper countdown
                S_TICK:
                begin
                    if (idx_reg >= scnt_reg)
                    begin
                        scnt_reg  <= kept_reg;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        slot_sel_reg <= cur_slot;
                        rem_rd_reg   <= rem_reg[cur_slot];
                        state_reg    <= S_TICKWR;
                    end
                end
                // decrement through shared unit, wake or compact
                S_TICKWR:
                begin
                    rem_reg[slot_sel_reg] <= crsp.value;
                    if (crsp.expire)
                    begin
                        slot_reg[slot_sel_reg] <= SLOT_READY;
                        if (rcnt_reg < CW'(TASK_SLOTS))
                        begin
                            rq_reg[tail_idx] <= slot_sel_reg;
                            rcnt_reg <= rcnt_reg + 1'b1;
                        end
                        woken_reg <= woken_reg + 1'b1;
                    end
                    else
                    begin
                        so_reg[kept_reg[SW-1:0]] <= slot_sel_reg;
                        kept_reg <= kept_reg + 1'b1;
                    end
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= S_TICK;
                end
                S_DONE:
                    state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- rtl/core/fifo_task_scheduler_with_sleep_core.sv -----
`timescale 1ns / 1ps
// Channel   Dir  Fields (lsb first)
// s_axis    in   tdata: operation[1:0], sleep_units[17:2], image_ok[18]
// m_axis    out  tdata: status[1:0], new_task_id[5:2], running_valid[6],
//                       running_id[10:7], woken_count[15:11]
// cfg       in   cfg_data: ticks_per_unit[9:0]
//
// Create scans the slots one per cycle, lowest free first.
// Tick fetches and decrements each sleeper in turn through the shared countdown unit.
// s_axis_tready is low while an item runs.
// A result waits in the output register; no new item is taken until it leaves.
// Reset frees all slots and empties both lists; ticks_per_unit returns to 100.
module fifo_task_scheduler_with_sleep_core
    import fts_pkg::*;
#(
    parameter int TASK_SLOTS = DEF_TASK_SLOTS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // operation, sleep_units, image_ok
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // status, new_task_id, running_valid,
                                        // running_id, woken_count
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data        // ticks_per_unit
);

    logic [TPU_W-1:0] tpu_reg;
    logic busy, done, run_valid, start;
    logic [1:0] status;
    logic [3:0] new_id, run_id;
    logic [4:0] woken;
    logic       mvalid_reg;
    logic [15:0] mdata_reg;
    logic [7:0] unused_in;

    assign unused_in = s_axis_tdata[23:16];
    assign cfg_ready = 1'b1;
    assign s_axis_tready = !busy && !(mvalid_reg && !m_axis_tready);
    assign start = s_axis_tvalid && s_axis_tready;

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tpu_reg <= TPU_RESET;
        else if (cfg_valid)
            tpu_reg <= cfg_data[TPU_W-1:0];
    end

    fts_seq #(.TASK_SLOTS(TASK_SLOTS)) u_seq (
        .clk(clk), .rst_n(rst_n), .start(start),
        .op_in(s_axis_tdata[1:0]), .units_in(s_axis_tdata[17:2]),
        .image_in(s_axis_tdata[18]), .tpu(tpu_reg),
        .busy(busy), .done(done), .status(status), .new_id(new_id),
        .run_valid(run_valid), .run_id(run_id), .woken(woken)
    );

    // output register; sequencer returns from DONE to IDLE unconditionally, so hold it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mvalid_reg <= 1'b0;
        else if (done)
        begin
            mvalid_reg <= 1'b1;
            mdata_reg  <= {woken, run_id, run_valid, new_id, status};
        end
        else if (m_axis_tready)
            mvalid_reg <= 1'b0;
    end

    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tdata  = mdata_reg;

endmodule

// ----- rtl/core/fts_checker.sv -----
`timescale 1ns / 1ps
module fts_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // held result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // input is not ready on the edge after a transfer
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("accepted back to back");

    // no running task means running id zero
    a_run: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[6] |-> m_axis_tdata[10:7] == 4'd0)
        else $error("running id without running task");

    // a failed create gives no slot id
    a_fail: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] != 2'd0 |-> m_axis_tdata[5:2] == 4'd0)
        else $error("slot id on failure");

endmodule

bind fifo_task_scheduler_with_sleep_core fts_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
module tb;
    import fts_pkg::*;

    localparam int SLOTS = 16;

    typedef struct packed {
        logic [4:0] woken;
        logic [3:0] run_id;
        logic       run_ok;
        logic [3:0] new_id;
        logic [1:0] status;
    } sched_rsp_t;

    typedef struct {
        op_t         op;
        logic [15:0] units;
        logic        image;
        logic        has_exp;
        sched_rsp_t  exp;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;

    // scheduler shadow state
    slot_state_t sh_slot [SLOTS];
    logic [3:0]  sh_rdy_q [SLOTS];
    int          sh_rdy_head, sh_rdy_cnt;
    logic [3:0]  sh_sleep_q [SLOTS];
    int          sh_sleep_cnt;
    logic [31:0] sh_left [SLOTS];
    logic [9:0]  sh_tpu;

    sched_rsp_t  pending_rsp [$];
    int          errors = 0;
    int          n_rsp = 0;
    int          n_wake = 0;
    bit          rx_stall_en = 1'b1;

    fifo_task_scheduler_with_sleep_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic void shadow_reset();
        for (int i = 0; i < SLOTS; i++)
        begin
            sh_slot[i] = SLOT_FREE;
            sh_rdy_q[i] = '0;
            sh_sleep_q[i] = '0;
            sh_left[i] = '0;
        end
        sh_rdy_head = 0;
        sh_rdy_cnt = 0;
        sh_sleep_cnt = 0;
        sh_tpu = TPU_RESET;
    endfunction

    function automatic void rdy_push(logic [3:0] s);
        if (sh_rdy_cnt < SLOTS)
        begin
            sh_rdy_q[(sh_rdy_head + sh_rdy_cnt) % SLOTS] = s;
            sh_rdy_cnt++;
        end
    endfunction

    // Advance the shadow scheduler by one transfer and return its response
    function automatic sched_rsp_t sched_apply(op_t op, logic [15:0] units, logic image);
        sched_rsp_t r;
        int         slot;
        int         kept;
        logic [3:0] s;
        r = '0;
        case (op)
            OP_CREATE:
            begin
                slot = SLOTS;
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (sh_slot[i] == SLOT_FREE)
                        slot = i;
                if (slot == SLOTS)
                    r.status = ST_NO_SLOT;
                else if (!image)
                    r.status = ST_IMAGE;
                else
                begin
                    sh_slot[slot] = SLOT_READY;
                    rdy_push(slot[3:0]);
                    r.new_id = slot[3:0];
                end
            end
            OP_SLEEP, OP_TERMINATE:
            begin
                if (sh_rdy_cnt == 0)
                    r.status = ST_NO_RUN;
                else
                begin
                    s = sh_rdy_q[sh_rdy_head];
                    sh_rdy_head = (sh_rdy_head + 1) % SLOTS;
                    sh_rdy_cnt--;
                    if (op == OP_TERMINATE)
                        sh_slot[s] = SLOT_DONE;
                    else if (sh_sleep_cnt < SLOTS)
                    begin
                        sh_slot[s] = SLOT_SLEEPING;
                        sh_left[s] = 32'(units) * 32'(sh_tpu);
                        sh_sleep_q[sh_sleep_cnt] = s;
                        sh_sleep_cnt++;
                    end
                end
            end
            default:
            begin
                kept = 0;
                for (int i = 0; i < sh_sleep_cnt; i++)
                begin
                    s = sh_sleep_q[i];
                    if (sh_left[s] <= 1)
                    begin
                        sh_left[s] = '0;
                        sh_slot[s] = SLOT_READY;
                        rdy_push(s);
                        r.woken++;
                    end
                    else
                    begin
                        sh_left[s]--;
                        sh_sleep_q[kept] = s;
                        kept++;
                    end
                end
                sh_sleep_cnt = kept;
            end
        endcase
        r.run_ok = (sh_rdy_cnt != 0);
        r.run_id = r.run_ok ? sh_rdy_q[sh_rdy_head] : 4'd0;
        return r;
    endfunction

    // valid stays high after the transfer; the next call or a drain updates it
    task automatic send_item(op_t op, logic [15:0] units, logic image, bit use_exp,
                             sched_rsp_t exp_r, bit gaps);
        sched_rsp_t p;
        p = sched_apply(op, units, image);
        if (use_exp && p !== exp_r)
            $display("note: predictor differs from table row, op %s", op.name());
        pending_rsp.push_back(use_exp ? exp_r : p);
        if (gaps)
            while ($urandom_range(99) < 34)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, image, units, op};
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic drain_rsp();
        s_axis_tvalid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_tpu(logic [9:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= {6'd0, v};
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sh_tpu = v;
    endtask

    // Receiver side: random back-pressure and field compare
    always @(posedge clk)
    begin
        sched_rsp_t got, want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                n_rsp++;
                if (pending_rsp.size() == 0)
                begin
                    $error("unexpected transfer: %h", m_axis_tdata);
                    errors++;
                end
                else
                begin
                    want = pending_rsp.pop_front();
                    n_wake += got.woken;
                    if (got.status !== want.status)
                    begin
                        $error("status exp %0d got %0d", want.status, got.status);
                        errors++;
                    end
                    if (got.new_id !== want.new_id)
                    begin
                        $error("new_task_id exp %0d got %0d", want.new_id, got.new_id);
                        errors++;
                    end
                    if (got.run_ok !== want.run_ok)
                    begin
                        $error("running_valid exp %0d got %0d", want.run_ok, got.run_ok);
                        errors++;
                    end
                    if (got.run_id !== want.run_id)
                    begin
                        $error("running_id exp %0d got %0d", want.run_id, got.run_id);
                        errors++;
                    end
                    if (got.woken !== want.woken)
                    begin
                        $error("woken_count exp %0d got %0d", want.woken, got.woken);
                        errors++;
                    end
                end
            end
            m_axis_tready <= rx_stall_en ? ($urandom_range(99) >= 34) : 1'b1;
        end
    end

    // Timeout guard
    initial
    begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

    // Stimulus
    initial
    begin
        dir_row_t   dir_tab [$];
        dir_row_t   row;
        sched_rsp_t z;
        op_t        op;
        logic [15:0] u;
        int         pick;
        int         n_ops;

        shadow_reset();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        z = '0;
        // reset state: nothing running, no sleepers
        row = '{OP_SLEEP, 16'd5, 1'b0, 1'b1, '{5'd0, 4'd0, 1'b0, 4'd0, ST_NO_RUN}};
        dir_tab.push_back(row);
        row = '{OP_TERMINATE, 16'hFFFF, 1'b1, 1'b1, '{5'd0, 4'd0, 1'b0, 4'd0, ST_NO_RUN}};
        dir_tab.push_back(row);
        row = '{OP_TICK, 16'hFFFF, 1'b1, 1'b1, '{5'd0, 4'd0, 1'b0, 4'd0, ST_OK}};
        dir_tab.push_back(row);
        row = '{OP_CREATE, 16'hFFFF, 1'b0, 1'b1, '{5'd0, 4'd0, 1'b0, 4'd0, ST_IMAGE}};
        dir_tab.push_back(row);
        row = '{OP_CREATE, 16'd0, 1'b1, 1'b1, '{5'd0, 4'd0, 1'b1, 4'd0, ST_OK}};
        dir_tab.push_back(row);
        row = '{OP_CREATE, 16'd0, 1'b1, 1'b1, '{5'd0, 4'd0, 1'b1, 4'd1, ST_OK}};
        dir_tab.push_back(row);
        // zero-length sleep then wake on the next tick
        row = '{OP_SLEEP, 16'd0, 1'b0, 1'b0, z};
        dir_tab.push_back(row);
        row = '{OP_TICK, 16'd0, 1'b0, 1'b0, z};
        dir_tab.push_back(row);
        row = '{OP_SLEEP, 16'd1, 1'b1, 1'b0, z};
        dir_tab.push_back(row);
        row = '{OP_TICK, 16'd0, 1'b0, 1'b0, z};
        dir_tab.push_back(row);
        row = '{OP_TERMINATE, 16'd0, 1'b0, 1'b0, z};
        dir_tab.push_back(row);
        // fill the table to hit the no-free-slot case
        for (int i = 0; i < 15; i++)
        begin
            row = '{OP_CREATE, 16'd0, 1'b1, 1'b0, z};
            dir_tab.push_back(row);
        end
        row = '{OP_CREATE, 16'd0, 1'b0, 1'b0, z};
        dir_tab.push_back(row);

        foreach (dir_tab[i])
            send_item(dir_tab[i].op, dir_tab[i].units, dir_tab[i].image,
                      dir_tab[i].has_exp, dir_tab[i].exp, 1'b1);
        drain_rsp();

        // random phases; reset clears nothing more, so slots run out and
        // later phases exercise ticks, sleeps and no-slot creates
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: write_tpu(10'd1);
                1: write_tpu(10'd1000);
                2: write_tpu(10'd0);
                3: write_tpu(10'h3FF);
                4: write_tpu(10'($urandom_range(2, 5)));
                default: write_tpu(10'd1);
            endcase
            rx_stall_en = (ph != 5);
            n_ops = 190;
            for (int k = 0; k < n_ops; k++)
            begin
                pick = $urandom_range(99);
                if (pick < 15)
                    op = OP_CREATE;
                else if (pick < 40)
                    op = OP_SLEEP;
                else if (pick < 50)
                    op = OP_TERMINATE;
                else
                    op = OP_TICK;
                u = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(3));
                send_item(op, u, ($urandom_range(3) != 0), 1'b0, z, ph != 5);
                if (k == 95)
                    drain_rsp();
            end
            drain_rsp();
        end

        $display("run: %0d responses checked, %0d wake-ups, six tick-rate settings",
                 n_rsp, n_wake);
        if (errors == 0 && pending_rsp.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
